// ----- hw/rtl/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// types and constants shared by the set associative cache core
// ----------------------------------------------------------------------------
`default_nettype none
package sacl_pkg;

  localparam int ADDR_W = 48;
  localparam int CNT_W  = 32;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;
  localparam logic [1:0] REG_USE_LRU     = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
  } sacl_req_t;

  typedef struct packed {
    logic             hit;
    logic             memory_read;
    logic             memory_write;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] fetch_total;
    logic [CNT_W-1:0] store_total;
  } sacl_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/set_assoc_cache_lru_fifo_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_fifo_core
// set associative cache tag model with lru or fifo replacement
// ----------------------------------------------------------------------------
// sequence: start captures the request and reads its set row; the update state then
//   writes the row back and raises the result strobe. busy is high during update,
//   so a new request is taken only after the last one has written back its set row
// reset: a clearing pass over all 2^MAX_SET_BITS sets zeroes valid and rank words;
//   busy stays high during it. the receiver cannot stall results
`default_nettype none
module set_assoc_cache_lru_fifo_core
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int WAYS         = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire  sacl_req_t  req,
  output logic             busy,
  output logic             done,
  output sacl_rsp_t        rsp,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire  [3:0]       paddr,
  input  wire  [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SI_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_W  = $clog2(WAYS + 1);
  localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  typedef logic [WAYS-1:0][ADDR_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][RANK_W:0]   meta_row_t; // {valid, rank}

  logic [4:0] offset_bits;
  logic [3:0] set_bits;
  logic [3:0] ways_in_use;
  logic       use_lru;

  logic [1:0] state;
  logic [SI_W-1:0] clr_idx;
  logic [SI_W-1:0] set_idx;
  logic [ADDR_W-1:0] tag;
  logic       wr_mode;
  logic [CNT_W-1:0] hit_counter, miss_counter, fetch_counter, store_counter;

  tag_row_t  tag_mem  [SETS];
  meta_row_t meta_mem [SETS];
  tag_row_t  tag_rd;
  meta_row_t meta_rd;

  // address split
  logic [SB_W-1:0]   sb;
  logic [ADDR_W-1:0] shifted;
  logic [ADDR_W-1:0] set_mask;
  logic [SI_W-1:0]   set_now;
  logic [ADDR_W-1:0] tag_now;
  logic [5:0]        tag_sh;

  always_comb begin
    sb = (set_bits > 4'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits);
    shifted  = req.address >> offset_bits;
    set_mask = (ADDR_W'(1) << sb) - ADDR_W'(1);
    set_now  = SI_W'(shifted & set_mask);
    tag_sh   = 6'(offset_bits) + 6'(sb);
    tag_now  = (tag_sh >= 6'(ADDR_W)) ? '0 : (req.address >> tag_sh);
  end

  wire accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;

  // lookup and replacement over the read row
  logic [WAY_W-1:0] nw;
  logic [WAYS-1:0]  in_use, vld, match;
  logic             hit;
  logic [RANK_W-1:0] hit_rank;
  logic [$clog2(WAYS+1)-1:0] hit_way, tgt;
  logic             found_inv;
  logic [RANK_W-1:0] best;
  meta_row_t        meta_wr;
  tag_row_t         tag_wr;

  always_comb begin
    if (ways_in_use == 4'd0) nw = WAY_W'(1);
    else if (32'(ways_in_use) > WAYS) nw = WAY_W'(WAYS);
    else nw = WAY_W'(ways_in_use);
    hit = 1'b0;
    hit_way = '0;
    found_inv = 1'b0;
    tgt = '0;
    best = '0;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (WAY_W'(w) < nw);
      vld[w]    = meta_rd[w][RANK_W];
      match[w]  = in_use[w] && vld[w] && (tag_rd[w] == tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit = 1'b1;
        hit_way = $bits(hit_way)'(w);
      end
      if (in_use[w] && !vld[w]) begin
        found_inv = 1'b1;
        tgt = $bits(tgt)'(w);
      end
    end
    if (!found_inv) begin
      best = meta_rd[0][RANK_W-1:0];
      tgt = '0;
      for (int w = 1; w < WAYS; w++) begin
        if (in_use[w] && meta_rd[w][RANK_W-1:0] > best) begin
          best = meta_rd[w][RANK_W-1:0];
          tgt = $bits(tgt)'(w);
        end
      end
    end
    hit_rank = meta_rd[hit_way[RANK_W-1:0]][RANK_W-1:0];
    meta_wr = meta_rd;
    tag_wr  = tag_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (hit) begin
        if (use_lru && in_use[w]) begin
          if ($bits(hit_way)'(w) == hit_way) meta_wr[w][RANK_W-1:0] = '0;
          else if (vld[w] && meta_rd[w][RANK_W-1:0] < hit_rank)
            meta_wr[w][RANK_W-1:0] = meta_rd[w][RANK_W-1:0] + 1'b1;
        end
      end else if (in_use[w]) begin
        if ($bits(tgt)'(w) == tgt) begin
          meta_wr[w] = {1'b1, {RANK_W{1'b0}}};
          tag_wr[w]  = tag;
        end else if (vld[w] && meta_rd[w][RANK_W-1:0] < RANK_MAX) begin
          meta_wr[w][RANK_W-1:0] = meta_rd[w][RANK_W-1:0] + 1'b1;
        end
      end
    end
  end

  // set memories
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      meta_mem[clr_idx] <= '0;
    end else if (state == ST_UPDATE) begin
      meta_mem[set_idx] <= meta_wr;
      tag_mem[set_idx]  <= tag_wr;
    end
    meta_rd <= meta_mem[set_now];
    tag_rd  <= tag_mem[set_now];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      done <= 1'b0;
      offset_bits <= 5'd6;
      set_bits <= 4'd0;
      ways_in_use <= 4'd1;
      use_lru <= 1'b1;
      hit_counter <= '0;
      miss_counter <= '0;
      fetch_counter <= '0;
      store_counter <= '0;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_OFFSET_BITS: offset_bits <= pwdata[4:0];
          REG_SET_BITS:    set_bits <= pwdata[3:0];
          REG_WAYS_IN_USE: ways_in_use <= pwdata[3:0];
          REG_USE_LRU:     use_lru <= pwdata[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SI_W'(SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          done <= 1'b1;
          if (hit) hit_counter <= hit_counter + 1'b1;
          else begin
            miss_counter <= miss_counter + 1'b1;
            fetch_counter <= fetch_counter + 1'b1;
          end
          if (wr_mode) store_counter <= store_counter + 1'b1;
          rsp.hit <= hit;
          rsp.memory_read <= !hit;
          rsp.memory_write <= wr_mode;
          rsp.hit_total <= hit_counter + CNT_W'(hit);
          rsp.miss_total <= miss_counter + CNT_W'(!hit);
          rsp.fetch_total <= fetch_counter + CNT_W'(!hit);
          rsp.store_total <= store_counter + CNT_W'(wr_mode);
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_idx <= set_now;
      tag <= tag_now;
      wr_mode <= req.mode;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OFFSET_BITS: prdata = 32'(offset_bits);
      REG_SET_BITS:    prdata = 32'(set_bits);
      REG_WAYS_IN_USE: prdata = 32'(ways_in_use);
      REG_USE_LRU:     prdata = 32'(use_lru);
      default:         prdata = '0;
    endcase
  end

  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done) else $error("missing result");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.hit != rsp.memory_read)) else $error("hit and fetch disagree");
  a_miss_fetch: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.miss_total == rsp.fetch_total)) else $error("miss fetch mismatch");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// checks the set associative cache core against a behavioral cache model:
// config writes over apb, directed corner accesses, random, back-to-back and paused traffic
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import sacl_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  sacl_req_t   req = '0;
  logic        busy;
  logic        done;
  sacl_rsp_t   rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  set_assoc_cache_lru_fifo_core dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // model state
  logic [4:0]        m_offset;
  logic [3:0]        m_sets;
  logic [3:0]        m_ways;
  logic              m_lru;
  logic              m_valid [NSETS*NWAYS];
  logic [ADDR_W-1:0] m_tag   [NSETS*NWAYS];
  logic [2:0]        m_rank  [NSETS*NWAYS];
  logic [CNT_W-1:0]  m_hits, m_misses, m_fetches, m_stores;

  sacl_rsp_t expected_rsp[$];
  int        errors = 0;
  int        mismatches = 0;
  int        sent = 0;
  int        no_gap = 0;
  int        hits_seen = 0;

  function automatic sacl_rsp_t cache_access(sacl_req_t a);
    sacl_rsp_t r;
    int sb, nw, base, hw, tgt;
    logic [ADDR_W-1:0] setv, tg;
    logic h;
    logic [2:0] rk, best;
    sb = (m_sets > 8) ? 8 : m_sets;
    nw = (m_ways < 1) ? 1 : (m_ways > NWAYS ? NWAYS : m_ways);
    setv = (a.address >> m_offset) & ((48'd1 << sb) - 1);
    tg = a.address >> (m_offset + sb);
    base = int'(setv) * NWAYS;
    h = 1'b0;
    hw = 0;
    for (int w = 0; w < nw; w++)
      if (!h && m_valid[base+w] && m_tag[base+w] == tg) begin
        h = 1'b1;
        hw = w;
      end
    if (h) begin
      m_hits++;
      if (m_lru) begin
        rk = m_rank[base+hw];
        for (int w = 0; w < nw; w++)
          if (w != hw && m_valid[base+w] && m_rank[base+w] < rk) m_rank[base+w]++;
        m_rank[base+hw] = '0;
      end
    end else begin
      m_misses++;
      m_fetches++;
      tgt = -1;
      for (int w = 0; w < nw; w++)
        if (tgt < 0 && !m_valid[base+w]) tgt = w;
      if (tgt < 0) begin
        tgt = 0;
        best = m_rank[base];
        for (int w = 1; w < nw; w++)
          if (m_rank[base+w] > best) begin
            best = m_rank[base+w];
            tgt = w;
          end
      end
      for (int w = 0; w < nw; w++)
        if (w != tgt && m_valid[base+w] && m_rank[base+w] < 3'd7) m_rank[base+w]++;
      m_valid[base+tgt] = 1'b1;
      m_tag[base+tgt] = tg;
      m_rank[base+tgt] = '0;
    end
    if (a.mode) m_stores++;
    r.hit = h;
    r.memory_read = !h;
    r.memory_write = a.mode;
    r.hit_total = m_hits;
    r.miss_total = m_misses;
    r.fetch_total = m_fetches;
    r.store_total = m_stores;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %p", rsp);
      end else begin
        sacl_rsp_t e;
        e = expected_rsp.pop_front();
        if (rsp.hit) hits_seen++;
        if (rsp !== e) begin
          errors++;
          if (mismatches++ < 10) $display("mismatch: expected %p got %p", e, rsp);
        end
      end
    end
  end

  task automatic send_access(input logic mode, input logic [ADDR_W-1:0] addr);
    sacl_req_t a;
    if (no_gap == 0) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    a.mode = mode;
    a.address = addr;
    start <= 1'b1;
    req <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(cache_access(a));
    sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_OFFSET_BITS: m_offset = val[4:0];
      REG_SET_BITS:    m_sets = val[3:0];
      REG_WAYS_IN_USE: m_ways = val[3:0];
      REG_USE_LRU:     m_lru = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ob, input int sb, input int nw, input int lru);
    drain();
    write_reg(REG_OFFSET_BITS, ob);
    write_reg(REG_SET_BITS, sb);
    write_reg(REG_WAYS_IN_USE, nw);
    write_reg(REG_USE_LRU, lru);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed;
    send_access(1'b0, '0);
    send_access(1'b1, '0);
    send_access(1'b0, '1);
    send_access(1'b1, '1);
    send_access(1'b0, 48'h5555_5555_5555);
    send_access(1'b1, 48'hAAAA_AAAA_AAAA);
    set_config(0, 8, 8, 1);
    for (int i = 0; i < 9; i++) send_access(i[0], 48'(i) << 8);
    send_access(1'b0, 48'd0);
    set_config(16, 15, 0, 0);
    send_access(1'b0, 48'h1234_0000_0000);
    send_access(1'b1, 48'h1234_0000_0000);
    set_config(31, 0, 15, 1);
    send_access(1'b0, 48'hFFFF_FFFF_FFFF);
    send_access(1'b0, 48'h0000_7FFF_FFFF);
  endtask

  task automatic test_random(input int n, input int ob, input int sb, input int nw,
                             input int lru);
    logic [ADDR_W-1:0] pool[16];
    set_config(ob, sb, nw, lru);
    foreach (pool[i]) pool[i] = ADDR_W'({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_access(1'($urandom_range(1)),
                    pool[$urandom_range(15)] ^ 48'($urandom_range(3)));
      else
        send_access(1'($urandom_range(1)), ADDR_W'({$urandom, $urandom}));
    end
  endtask

  task automatic test_no_gap;
    no_gap = 1;
    test_random(150, 4, 2, 4, 1);
    no_gap = 0;
  endtask

  task automatic test_pause;
    for (int i = 0; i < 10; i++) send_access(1'b0, 48'(i) << 6);
    drain();
    for (int i = 0; i < 10; i++) send_access(1'b1, 48'(i) << 6);
  endtask

  initial begin
    m_offset = 5'd6; m_sets = '0; m_ways = 4'd1; m_lru = 1'b1;
    foreach (m_valid[i]) begin
      m_valid[i] = 1'b0; m_tag[i] = '0; m_rank[i] = '0;
    end
    m_hits = '0; m_misses = '0; m_fetches = '0; m_stores = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 6, 3, 8, 1);
    test_random(250, 2, 2, 4, 0);
    test_random(200, 0, 0, 1, 1);
    test_random(200, 16, 8, 8, 0);
    test_random(200, 5, 1, 3, 1);
    test_no_gap();
    test_pause();
    test_random(150, 3, 4, 2, 0);
    drain();
    repeat (10) @(posedge clk);
    $display("sent %0d accesses over several cache shapes, lru and fifo, %0d hits",
             sent, hits_seen);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
